@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on a rising edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pwno_pkg.sv @@
// ---------------------------------------------------------------------------
// pwno_pkg
// Types and constants of the path window nearest point offset unit.
// ---------------------------------------------------------------------------
package pwno_pkg;

   // stream widths
   localparam int REQ_TDATA_W = 200;
   localparam int RSP_TDATA_W = 48;

   // request tdata field positions, lowest bit up
   localparam int REQ_PIDX_LSB  = 0;
   localparam int REQ_PX_LSB    = 12;
   localparam int REQ_PY_LSB    = 44;
   localparam int REQ_COS_LSB   = 76;
   localparam int REQ_SIN_LSB   = 92;
   localparam int REQ_TX_LSB    = 108;
   localparam int REQ_TY_LSB    = 140;
   localparam int REQ_START_LSB = 172;
   localparam int REQ_END_LSB   = 184;

   // field widths
   localparam int IDX_W   = 12;
   localparam int END_W   = 13;
   localparam int COORD_W = 32;
   localparam int TRIG_W  = 16;
   localparam int CMP_W   = 17;   // holds any legal depth for index compares

   // datapath widths
   localparam int DELTA_W = 33;   // coordinate difference
   localparam int SQ_W    = 65;   // one squared difference
   localparam int DIST_W  = 66;   // sum of two squares
   localparam int PROD_W  = 49;   // delta times Q1.14 trig
   localparam int ROT_W   = 50;   // difference of the two products
   localparam int FRAC_W  = 14;

   localparam logic signed [COORD_W-1:0] OFF_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] OFF_MIN = 32'sh8000_0000;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [TRIG_W-1:0]  c;
      logic signed [TRIG_W-1:0]  s;
   } point_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_DELTA = 6'b001000,
      ST_MULT  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

@@ rtl/path_window_nearest_offset_unit.sv @@
// ---------------------------------------------------------------------------
// path_window_nearest_offset_unit
// Path point store with a windowed nearest point search and cross-track
// offset of the target against the heading of the chosen point.
// ---------------------------------------------------------------------------
// A load beat writes one point into a single-port synchronous memory. A
// query beat scans the window [start, end) with end clipped to PATH_DEPTH,
// reading one entry per cycle from that memory port; then the distance
// pipeline (read, delta, partial products, squares, sum) drains, the anchor
// entry is read, and the rotation runs through its delta, product and output
// states. An empty window skips the reads and the drain. Items are handled
// one at a time; the finished result sits in an output register, so the next
// beat is taken while it waits. The memory needs no clearing after reset:
// only entries that were loaded may be searched.
module path_window_nearest_offset_unit #(
   parameter int PATH_DEPTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = opcode
   // tdata = point_index, point_x, point_y, heading_cos, heading_sin,
   //         target_x, target_y, start_index, end_index, zero fill
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pwno_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,
   // response: tdata = nearest_index, lateral_offset, zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pwno_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import pwno_pkg::*;

   localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam logic [CMP_W-1:0] DEPTH_L = CMP_W'(PATH_DEPTH);

   // request field unpack
   logic [IDX_W-1:0]          f_pidx;
   point_type                 f_point;
   logic signed [COORD_W-1:0] f_tx, f_ty;
   logic [IDX_W-1:0]          f_start;
   logic [END_W-1:0]          f_end, f_end_clip;
   logic                      accept, is_query;

   assign f_pidx    = req_tdata[REQ_PIDX_LSB +: IDX_W];
   assign f_point.x = req_tdata[REQ_PX_LSB +: COORD_W];
   assign f_point.y = req_tdata[REQ_PY_LSB +: COORD_W];
   assign f_point.c = req_tdata[REQ_COS_LSB +: TRIG_W];
   assign f_point.s = req_tdata[REQ_SIN_LSB +: TRIG_W];
   assign f_tx      = req_tdata[REQ_TX_LSB +: COORD_W];
   assign f_ty      = req_tdata[REQ_TY_LSB +: COORD_W];
   assign f_start   = req_tdata[REQ_START_LSB +: IDX_W];
   assign f_end     = req_tdata[REQ_END_LSB +: END_W];
   assign f_end_clip = (CMP_W'(f_end) > DEPTH_L) ? END_W'(DEPTH_L) : f_end;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_query   = (opcode_type'(req_tuser) == OP_QUERY);

   // query context
   logic [END_W-1:0]          idx_ff, idx_in;
   logic [END_W-1:0]          end_ff;
   logic signed [COORD_W-1:0] tx_ff, ty_ff;

   // point memory, one read or write port, registered read
   point_type mem [PATH_DEPTH];
   point_type mem_q_ff;
   logic      wr_en, rd_en, issue;
   logic [AW-1:0] rd_addr;

   logic [IDX_W-1:0] best_idx_ff, best_idx_in;

   assign wr_en   = accept && !is_query && (CMP_W'(f_pidx) < DEPTH_L);
   assign issue   = (state_ff == ST_SCAN) && (idx_ff < end_ff);
   assign rd_en   = issue || (state_ff == ST_FETCH);
   assign rd_addr = issue ? AW'(idx_ff) : AW'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(f_pidx)] <= f_point;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // distance pipeline: read, delta, partial products, squares, sum
   logic                     rd_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [IDX_W-1:0]         rd_idx_ff, s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic signed [DELTA_W-1:0] sdx_in, sdy_in;
   logic [DELTA_W-1:0]       mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;
   logic [31:0]              xhh_ff, yhh_ff, xhh_in, yhh_in;
   logic [32:0]              xhl_ff, yhl_ff, xhl_in, yhl_in;
   logic [33:0]              xll_ff, yll_ff, xll_in, yll_in;
   logic [SQ_W-1:0]          sq_x_ff, sq_y_ff, sq_x_in, sq_y_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [DIST_W-1:0]        best_d_ff;
   logic                     found_ff, better;

   always_comb begin
      // stage 1: magnitudes of the deltas
      sdx_in   = {tx_ff[COORD_W-1], tx_ff} - {mem_q_ff.x[COORD_W-1], mem_q_ff.x};
      sdy_in   = {ty_ff[COORD_W-1], ty_ff} - {mem_q_ff.y[COORD_W-1], mem_q_ff.y};
      mag_x_in = sdx_in[DELTA_W-1] ? DELTA_W'(-sdx_in) : DELTA_W'(sdx_in);
      mag_y_in = sdy_in[DELTA_W-1] ? DELTA_W'(-sdy_in) : DELTA_W'(sdy_in);
      // stage 2: 16/17 bit split partial products
      xhh_in = 32'(mag_x_ff[32:17]) * 32'(mag_x_ff[32:17]);
      xhl_in = 33'(mag_x_ff[32:17]) * 33'(mag_x_ff[16:0]);
      xll_in = 34'(mag_x_ff[16:0]) * 34'(mag_x_ff[16:0]);
      yhh_in = 32'(mag_y_ff[32:17]) * 32'(mag_y_ff[32:17]);
      yhl_in = 33'(mag_y_ff[32:17]) * 33'(mag_y_ff[16:0]);
      yll_in = 34'(mag_y_ff[16:0]) * 34'(mag_y_ff[16:0]);
      // stage 3: assemble squares
      sq_x_in = SQ_W'({xhh_ff, 34'b0}) + SQ_W'({xhl_ff, 18'b0}) + SQ_W'(xll_ff);
      sq_y_in = SQ_W'({yhh_ff, 34'b0}) + SQ_W'({yhl_ff, 18'b0}) + SQ_W'(yll_ff);
      // stage 4: distance
      dist_in = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff);
      // stage 5: keep the first strict minimum
      better  = s4_v_ff && (!found_ff || (dist_ff < best_d_ff));
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= IDX_W'(idx_ff);
      s1_idx_ff <= rd_idx_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      xhh_ff    <= xhh_in;
      xhl_ff    <= xhl_in;
      xll_ff    <= xll_in;
      yhh_ff    <= yhh_in;
      yhl_ff    <= yhl_in;
      yll_ff    <= yll_in;
      sq_x_ff   <= sq_x_in;
      sq_y_ff   <= sq_y_in;
      dist_ff   <= dist_in;
      if (better) begin
         best_d_ff <= dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         rd_v_ff  <= issue;
         s1_v_ff  <= rd_v_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         if (accept && is_query) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
      end
   end

   // anchor rotation: delta, products, shift and saturate
   logic                      anchor_ok_ff;
   logic signed [COORD_W-1:0] ax_in, ay_in;
   logic signed [DELTA_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [TRIG_W-1:0]  c_ff, s_ff;
   logic signed [PROD_W-1:0]  prod_c_ff, prod_s_ff;
   logic signed [ROT_W-1:0]   rot_in;
   logic signed [ROT_W-FRAC_W-1:0] shr_in;
   logic signed [COORD_W-1:0] off_in;

   always_comb begin
      ax_in  = anchor_ok_ff ? mem_q_ff.x : '0;
      ay_in  = anchor_ok_ff ? mem_q_ff.y : '0;
      dx_in  = {tx_ff[COORD_W-1], tx_ff} - {ax_in[COORD_W-1], ax_in};
      dy_in  = {ty_ff[COORD_W-1], ty_ff} - {ay_in[COORD_W-1], ay_in};
      rot_in = ROT_W'(prod_c_ff) - ROT_W'(prod_s_ff);
      shr_in = rot_in[ROT_W-1:FRAC_W];
      // in range when the bits above the sign all match it
      if (shr_in[ROT_W-FRAC_W-1:COORD_W-1] == '0 ||
          shr_in[ROT_W-FRAC_W-1:COORD_W-1] == '1) begin
         off_in = shr_in[COORD_W-1:0];
      end else if (shr_in[ROT_W-FRAC_W-1]) begin
         off_in = OFF_MIN;
      end else begin
         off_in = OFF_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         anchor_ok_ff <= (CMP_W'(best_idx_ff) < DEPTH_L);
      end
      if (state_ff == ST_DELTA) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         c_ff  <= anchor_ok_ff ? mem_q_ff.c : '0;
         s_ff  <= anchor_ok_ff ? mem_q_ff.s : '0;
      end
      if (state_ff == ST_MULT) begin
         prod_c_ff <= PROD_W'(dx_ff) * PROD_W'(c_ff);
         prod_s_ff <= PROD_W'(dy_ff) * PROD_W'(s_ff);
      end
   end

   // output register
   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_idx_ff;
   logic signed [COORD_W-1:0] rsp_off_ff;
   logic                      out_free, out_load;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == ST_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_idx_ff <= best_idx_ff;
         rsp_off_ff <= off_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-IDX_W-COORD_W)'(0), rsp_off_ff, rsp_idx_ff};

   // sequencer
   logic pipe_busy;
   assign pipe_busy = rd_v_ff || s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      best_idx_in = best_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               state_in    = ST_SCAN;
               idx_in      = END_W'(f_start);
               best_idx_in = f_start;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + END_W'(1);
            end else if (!pipe_busy) begin
               state_in = ST_FETCH;
            end
            if (better) begin
               best_idx_in = s4_idx_ff;
            end
         end
         ST_FETCH: state_in = ST_DELTA;
         ST_DELTA: state_in = ST_MULT;
         ST_MULT:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      if (accept && is_query) begin
         end_ff <= f_end_clip;
         tx_ff  <= f_tx;
         ty_ff  <= f_ty;
      end
   end

endmodule

@@ rtl/pwno_checker.sv @@
// ---------------------------------------------------------------------------
// pwno_checker
// Port level checks of the path window nearest offset unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pwno_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [pwno_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [pwno_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import pwno_pkg::*;

   // outstanding queries and window of the latest one
   logic [1:0]       pend_ff, pend_in;
   logic [IDX_W-1:0] lq_start_ff;
   logic [END_W-1:0] lq_end_ff;
   logic             q_beat, r_beat;
   logic [IDX_W-1:0] r_idx;

   assign q_beat = req_tvalid && req_tready && (opcode_type'(req_tuser) == OP_QUERY);
   assign r_beat = rsp_tvalid && rsp_tready;
   assign r_idx  = rsp_tdata[IDX_W-1:0];

   always_comb begin
      pend_in = pend_ff;
      if (q_beat && !r_beat) begin
         pend_in = pend_ff + 2'd1;
      end else if (r_beat && !q_beat) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_beat) begin
         lq_start_ff <= req_tdata[REQ_START_LSB +: IDX_W];
         lq_end_ff   <= req_tdata[REQ_END_LSB +: END_W];
      end
   end

   // a response beat always answers an accepted query
   `ASSERT_SAME(a_rsp_has_query, clock, reset, rsp_tvalid, pend_ff != 2'd0,
      "response without an outstanding query")

   // one query in work plus one held result closes the input
   `ASSERT_SAME(a_full_stalls_req, clock, reset, pend_ff == 2'd2, !req_tready,
      "request taken with two queries outstanding")

   // result lies in the window, or is the start of an empty one
   `ASSERT_SAME(a_idx_in_window, clock, reset, rsp_tvalid && pend_ff == 2'd1,
      (r_idx == lq_start_ff) ||
      (r_idx > lq_start_ff && END_W'(r_idx) < lq_end_ff),
      "nearest index outside the query window")

   // stalled response beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

endmodule

bind path_window_nearest_offset_unit pwno_checker u_pwno_checker (.*);
